// File: hw/rtl/owsp_pkg.sv
`timescale 1ns / 1ps
package owsp_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int SIN_A = 51472;
    localparam int SIN_B = 21024;
    localparam int SIN_C = 2320;
    localparam int QUARTER_TURN = 16384;
    localparam int WHEEL2_OFS = 21845;
    localparam int WHEEL3_OFS = 43691;

    localparam logic [7:0]  RST_SPEED_GAIN    = 8'd60;
    localparam logic [7:0]  RST_SPIN_OFFSET   = 8'd40;
    localparam logic [9:0]  RST_P_GAIN        = 10'd100;
    localparam logic [13:0] RST_CURRENT_LIMIT = 14'd2500;

    // pipeline stage map
    localparam int SINE_STAGES = 5;
    localparam int ST_PROJ  = 5;
    localparam int ST_SUM   = 6;
    localparam int ST_TGT   = 7;
    localparam int ST_ERR   = 8;
    localparam int ST_PMUL  = 9;
    localparam int ST_PROD  = 10;
    localparam int ST_TRUNC = 11;
    localparam int ST_CLAMP = 12;
    localparam int NUM_STAGES = 13;
    localparam int SIDE_STAGES = ST_ERR;

    typedef enum logic [1:0] {
        CFG_SPEED_GAIN    = 2'd0,
        CFG_SPIN_OFFSET   = 2'd1,
        CFG_P_GAIN        = 2'd2,
        CFG_CURRENT_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  speed_gain;
        logic [7:0]  spin_offset;
        logic [9:0]  p_gain;
        logic [13:0] current_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic               spin_minus;
        logic               spin_plus;
        logic signed [17:0] speed_wheel1;
        logic signed [17:0] speed_wheel2;
        logic signed [17:0] speed_wheel3;
    } t_side;

endpackage

// File: hw/rtl/owsp_sine.sv
`timescale 1ns / 1ps
module owsp_sine #(
    parameter int SINE_TABLE_BITS = owsp_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic [owsp_pkg::SINE_STAGES-1:0]      i_en,
    input  logic [15:0]                           i_phase,
    output logic signed [17:0]                    o_sine
);
    import owsp_pkg::*;

    localparam int GRID = 16 - SINE_TABLE_BITS;

    logic [15:0] w_p;
    logic [15:0] w_u;
    logic [15:0] n_uu;
    logic [31:0] w_sq;
    logic [27:0] w_c;
    logic [31:0] w_d;
    logic [31:0] w_e;

    logic [15:0] r_uu  [4];
    logic        r_neg [4];
    logic [15:0] r_u2;
    logic [15:0] r_u2_d;
    logic [15:0] r_t1;
    logic [15:0] r_t3;
    logic signed [17:0] r_sine;

    assign w_p  = {i_phase[15:GRID], {GRID{1'b0}}};
    assign w_u  = {1'b0, w_p[13:0], 1'b0};
    assign n_uu = w_p[14] ? (16'(32768) - w_u) : w_u;

    assign w_sq = 32'(r_uu[0]) * 32'(r_uu[0]);
    assign w_c  = 28'(r_u2) * 28'(SIN_C);
    assign w_d  = 32'(r_t1) * 32'(r_u2_d);
    assign w_e  = 32'(r_t3) * 32'(r_uu[3]);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_uu[0]  <= n_uu;
            r_neg[0] <= w_p[15];
        end
        for (int k = 1; k < 4; k++) begin
            if (i_en[k]) begin
                r_uu[k]  <= r_uu[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
        if (i_en[1]) begin
            r_u2 <= w_sq[30:15];
        end
        if (i_en[2]) begin
            r_t1   <= 16'(SIN_B) - 16'(w_c[27:15]);
            r_u2_d <= r_u2;
        end
        if (i_en[3]) begin
            r_t3 <= 16'(17'(SIN_A) - w_d[31:15]);
        end
        if (i_en[4]) begin
            r_sine <= r_neg[3] ? -$signed({1'b0, w_e[31:15]}) : $signed({1'b0, w_e[31:15]});
        end
    end

    assign o_sine = r_sine;

endmodule

// File: hw/rtl/owsp_wheel.sv
`timescale 1ns / 1ps
module owsp_wheel #(
    parameter int SINE_TABLE_BITS = owsp_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic [owsp_pkg::NUM_STAGES-1:0]  i_en,
    input  owsp_pkg::t_cfg                   i_cfg,
    input  logic [15:0]                      i_phase,
    input  logic signed [15:0]               i_x,
    input  logic signed [15:0]               i_y,
    input  logic                             i_minus,
    input  logic                             i_plus,
    input  logic signed [17:0]               i_meas,
    output logic signed [14:0]               o_current
);
    import owsp_pkg::*;

    logic [15:0]        w_phase_cos;
    logic signed [17:0] w_sin;
    logic signed [17:0] w_cos;

    logic signed [33:0] w_px;
    logic signed [33:0] w_py;
    logic signed [43:0] w_tgt;
    logic signed [47:0] w_off;
    logic signed [47:0] w_adj;
    logic signed [47:0] w_meas;
    logic [31:0]        w_mlo;
    logic signed [36:0] w_mhi;
    logic [58:0]        w_bias;
    logic [58:0]        w_rnd;
    logic signed [28:0] w_lim;
    logic signed [14:0] n_out;

    logic signed [33:0] r_px;
    logic signed [33:0] r_py;
    logic signed [34:0] r_sum;
    logic signed [43:0] r_tgt;
    logic signed [47:0] r_err;
    logic [31:0]        r_mlo;
    logic signed [36:0] r_mhi;
    logic signed [58:0] r_prod;
    logic signed [28:0] r_cur;
    logic signed [14:0] r_out;

    assign w_phase_cos = i_phase + 16'(QUARTER_TURN);

    owsp_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sin (
        .i_clk   (i_clk),
        .i_en    (i_en[SINE_STAGES-1:0]),
        .i_phase (i_phase),
        .o_sine  (w_sin)
    );

    owsp_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cos (
        .i_clk   (i_clk),
        .i_en    (i_en[SINE_STAGES-1:0]),
        .i_phase (w_phase_cos),
        .o_sine  (w_cos)
    );

    assign w_px   = i_x * w_cos;
    assign w_py   = i_y * w_sin;
    assign w_tgt  = $signed({1'b0, i_cfg.speed_gain}) * r_sum;
    assign w_off  = $signed({10'b0, i_cfg.spin_offset, 30'b0});
    assign w_meas = 48'(i_meas) <<< 22;

    always_comb begin
        case ({i_minus, i_plus})
            2'b10:   w_adj = -w_off;
            2'b01:   w_adj = w_off;
            default: w_adj = '0;
        endcase
    end

    assign w_mlo  = 32'(i_cfg.p_gain) * 32'(r_err[21:0]);
    assign w_mhi  = $signed({1'b0, i_cfg.p_gain}) * $signed(r_err[47:22]);
    assign w_bias = r_prod[58] ? 59'(30'h3FFF_FFFF) : '0;
    assign w_rnd  = r_prod + w_bias;
    assign w_lim  = $signed(29'(i_cfg.current_limit));

    always_comb begin
        if (r_cur > w_lim) begin
            n_out = 15'(w_lim);
        end else if (r_cur < -w_lim) begin
            n_out = 15'(-w_lim);
        end else begin
            n_out = 15'(r_cur);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_PROJ]) begin
            r_px <= w_px;
            r_py <= w_py;
        end
        if (i_en[ST_SUM]) begin
            r_sum <= 35'(r_px) + 35'(r_py);
        end
        if (i_en[ST_TGT]) begin
            r_tgt <= w_tgt;
        end
        if (i_en[ST_ERR]) begin
            r_err <= 48'(r_tgt) - w_meas + w_adj;
        end
        if (i_en[ST_PMUL]) begin
            r_mlo <= w_mlo;
            r_mhi <= w_mhi;
        end
        if (i_en[ST_PROD]) begin
            r_prod <= (59'(r_mhi) <<< 22) + 59'(r_mlo);
        end
        if (i_en[ST_TRUNC]) begin
            r_cur <= $signed(w_rnd[58:30]);
        end
        if (i_en[ST_CLAMP]) begin
            r_out <= n_out;
        end
    end

    assign o_current = r_out;

endmodule

// File: hw/rtl/omni_wheel_speed_p_control_core.sv
`timescale 1ns / 1ps
// Three-wheel omni drive speed controller. Each request carries the stick
// vector, heading, spin buttons and measured wheel speeds; one response with
// three clamped motor currents comes out after passing 13 register stages.
// A request can be taken every cycle unless output back-pressure has filled the
// pipeline. The depth is set by the five-stage sine polynomial (a chain of
// multipliers) followed by projection, gain and the proportional controller
// stages. Stalls on the output side only hold stages that are full.
// Configuration: index 0 speed_gain, 1 spin_offset, 2 p_gain, 3 current_limit;
// write only while no request is in flight.
module omni_wheel_speed_p_control_core #(
    parameter int SINE_TABLE_BITS = owsp_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [13:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // stick_x, stick_y, heading, spin_minus, spin_plus,
    // speed_wheel1, speed_wheel2, speed_wheel3
    input  logic [103:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // current_wheel1, current_wheel2, current_wheel3, 3 bits zero pad
    output logic [47:0]  o_m_tdata
);
    import owsp_pkg::*;

    t_cfg                  r_cfg;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;
    t_side                 r_side [SIDE_STAGES];
    t_side                 w_side_in;

    logic [15:0]        w_head;
    logic [15:0]        w_phase [3];
    logic signed [17:0] w_meas  [3];
    logic signed [14:0] w_cur   [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_gain    <= RST_SPEED_GAIN;
            r_cfg.spin_offset   <= RST_SPIN_OFFSET;
            r_cfg.p_gain        <= RST_P_GAIN;
            r_cfg.current_limit <= RST_CURRENT_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SPEED_GAIN:    r_cfg.speed_gain    <= i_cfg_data[7:0];
                CFG_SPIN_OFFSET:   r_cfg.spin_offset   <= i_cfg_data[7:0];
                CFG_P_GAIN:        r_cfg.p_gain        <= i_cfg_data[9:0];
                CFG_CURRENT_LIMIT: r_cfg.current_limit <= i_cfg_data;
            endcase
        end
    end

    // per-stage advance: a stage loads when empty or when the next one moves
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = w_en[0];
    assign o_m_tvalid = r_vld[NUM_STAGES-1];

    assign w_side_in.stick_x      = $signed(i_s_tdata[15:0]);
    assign w_side_in.stick_y      = $signed(i_s_tdata[31:16]);
    assign w_side_in.spin_minus   = i_s_tdata[48];
    assign w_side_in.spin_plus    = i_s_tdata[49];
    assign w_side_in.speed_wheel1 = $signed(i_s_tdata[67:50]);
    assign w_side_in.speed_wheel2 = $signed(i_s_tdata[85:68]);
    assign w_side_in.speed_wheel3 = $signed(i_s_tdata[103:86]);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= w_side_in;
        end
        for (int k = 1; k < SIDE_STAGES; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign w_head     = i_s_tdata[47:32];
    assign w_phase[0] = 16'd0 - w_head;
    assign w_phase[1] = w_phase[0] + 16'(WHEEL2_OFS);
    assign w_phase[2] = w_phase[0] + 16'(WHEEL3_OFS);

    assign w_meas[0] = r_side[SIDE_STAGES-1].speed_wheel1;
    assign w_meas[1] = r_side[SIDE_STAGES-1].speed_wheel2;
    assign w_meas[2] = r_side[SIDE_STAGES-1].speed_wheel3;

    for (genvar g = 0; g < 3; g++) begin : g_wheel
        owsp_wheel #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_wheel (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_cfg     (r_cfg),
            .i_phase   (w_phase[g]),
            .i_x       (r_side[SINE_STAGES-1].stick_x),
            .i_y       (r_side[SINE_STAGES-1].stick_y),
            .i_minus   (r_side[SIDE_STAGES-1].spin_minus),
            .i_plus    (r_side[SIDE_STAGES-1].spin_plus),
            .i_meas    (w_meas[g]),
            .o_current (w_cur[g])
        );
    end

    assign o_m_tdata = {3'b000, w_cur[2], w_cur[1], w_cur[0]};

endmodule
